### hw/rtl/u8d_pkg.sv
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types and constants for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

   localparam int BYTE_W  = 8;
   localparam int CODE_W  = 21;
   localparam int CSR_IDX_W = 1;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [CODE_W-1:0] REPLACEMENT_RESET = 21'h00FFFD;
   localparam logic [CODE_W-1:0] CODE_LIMIT_RESET  = 21'h10FFFF;

   localparam logic [CSR_IDX_W-1:0] CSR_REPLACEMENT_CODE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CODE_LIMIT       = 1'd1;

   // Byte classification constants.
   localparam logic [BYTE_W-1:0] LEAD_C0  = 8'hC0;
   localparam logic [BYTE_W-1:0] LEAD_C1  = 8'hC1;
   localparam logic [BYTE_W-1:0] LEAD_F5  = 8'hF5;

   // What a command finishes with, after its replacements.
   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_VALUE,
      KIND_REPLACE
   } u8d_kind_type;

   typedef struct packed {
      logic [1:0]        rep_count;
      u8d_kind_type      kind;
      logic [CODE_W-1:0] value;
   } u8d_cmd_type;

endpackage

### hw/rtl/u8d_front.sv
// ----------------------------------------------------------------------------
// u8d_front
// Accepts bytes, tracks the open sequence and turns each byte into a command, pushing only those that give output.
// ----------------------------------------------------------------------------
module u8d_front
   import u8d_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [BYTE_W-1:0] req_tdata,     // [7:0] byte_in
   input  logic              queue_full,
   output logic              push_valid,
   output u8d_cmd_type       push_cmd
);

   logic [CODE_W-1:0] partial_ff, partial_in;
   logic [1:0]        expected_ff, expected_in;
   logic [1:0]        held_ff, held_in;
   logic              accept;
   logic              is_cont;
   logic              bad_lead;
   u8d_cmd_type       cmd;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;
   assign is_cont    = (req_tdata[7:6] == 2'b10);
   assign bad_lead   = is_cont || (req_tdata == LEAD_C0) || (req_tdata == LEAD_C1)
                       || (req_tdata >= LEAD_F5);

   always_comb begin
      partial_in    = partial_ff;
      expected_in   = expected_ff;
      held_in       = held_ff;
      cmd.rep_count = 2'd0;
      cmd.kind      = KIND_NONE;
      cmd.value     = '0;
      if (expected_ff != 2'd0 && is_cont) begin
         if (expected_ff == 2'd1) begin
            cmd.kind    = KIND_VALUE;
            cmd.value   = {partial_ff[CODE_W-7:0], req_tdata[5:0]};
            partial_in  = '0;
            expected_in = 2'd0;
            held_in     = 2'd0;
         end else begin
            partial_in  = {partial_ff[CODE_W-7:0], req_tdata[5:0]};
            expected_in = 2'(expected_ff - 2'd1);
            held_in     = 2'(held_ff + 2'd1);
         end
      end else begin
         // An interrupted sequence is flushed with one replacement per byte held.
         if (expected_ff != 2'd0) begin
            cmd.rep_count = held_ff;
         end
         partial_in  = '0;
         expected_in = 2'd0;
         held_in     = 2'd0;
         if (bad_lead) begin
            cmd.kind = KIND_REPLACE;
         end else if (!req_tdata[7]) begin
            cmd.kind  = KIND_VALUE;
            cmd.value = CODE_W'(req_tdata);
         end else if (req_tdata[7:5] == 3'b110) begin
            partial_in  = CODE_W'(req_tdata[4:0]);
            expected_in = 2'd1;
            held_in     = 2'd1;
         end else if (req_tdata[7:4] == 4'b1110) begin
            partial_in  = CODE_W'(req_tdata[3:0]);
            expected_in = 2'd2;
            held_in     = 2'd1;
         end else begin
            partial_in  = CODE_W'(req_tdata[2:0]);
            expected_in = 2'd3;
            held_in     = 2'd1;
         end
      end
   end

   assign push_valid = accept && ((cmd.rep_count != 2'd0) || (cmd.kind != KIND_NONE));
   assign push_cmd   = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff  <= '0;
         expected_ff <= 2'd0;
         held_ff     <= 2'd0;
      end else if (accept) begin
         partial_ff  <= partial_in;
         expected_ff <= expected_in;
         held_ff     <= held_in;
      end
   end

endmodule

### hw/rtl/u8d_queue.sv
// ----------------------------------------------------------------------------
// u8d_queue
// Small command queue between the front and back parts.
// ----------------------------------------------------------------------------
module u8d_queue
   import u8d_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        push_valid,
   input  u8d_cmd_type push_cmd,
   output logic        full,
   input  logic        pop,
   output logic        head_valid,
   output u8d_cmd_type head_cmd
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   u8d_cmd_type      entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
      end
      if (do_push && !do_pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### hw/rtl/u8d_back.sv
// ----------------------------------------------------------------------------
// u8d_back
// Expands queued commands into result transactions through an output register.
// ----------------------------------------------------------------------------
module u8d_back
   import u8d_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [CODE_W-1:0]   replacement_code,
   input  logic [CODE_W-1:0]   code_limit,
   input  logic                head_valid,
   input  u8d_cmd_type         head_cmd,
   output logic                pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [23:0]         rsp_tdata,   // [20:0] code_point, [23:21] zero
   output logic [0:0]          rsp_tuser,   // [0] was_replaced
   output logic                rsp_tlast    // last_of_run
);

   logic              valid_ff, valid_in;
   logic [CODE_W-1:0] code_ff, code_in;
   logic              repl_ff, repl_in;
   logic              last_ff, last_in;
   logic [1:0]        idx_ff, idx_in;
   logic              slot_free;
   logic              load;

   assign slot_free = !valid_ff || rsp_tready;

   always_comb begin
      pop     = 1'b0;
      load    = 1'b0;
      idx_in  = idx_ff;
      code_in = code_ff;
      repl_in = repl_ff;
      last_in = last_ff;
      if (slot_free && head_valid) begin
         if (idx_ff != head_cmd.rep_count) begin
            load    = 1'b1;
            code_in = replacement_code;
            repl_in = 1'b1;
            last_in = 1'b0;
            // With nothing to follow the last replacement, retire the command now.
            if ((2'(idx_ff + 2'd1) == head_cmd.rep_count) && (head_cmd.kind == KIND_NONE)) begin
               pop    = 1'b1;
               idx_in = 2'd0;
            end else begin
               idx_in = 2'(idx_ff + 2'd1);
            end
         end else begin
            pop    = 1'b1;
            idx_in = 2'd0;
            case (head_cmd.kind)
               KIND_VALUE: begin
                  load    = 1'b1;
                  last_in = 1'b1;
                  if (head_cmd.value > code_limit) begin
                     code_in = replacement_code;
                     repl_in = 1'b1;
                  end else begin
                     code_in = head_cmd.value;
                     repl_in = 1'b0;
                  end
               end
               KIND_REPLACE: begin
                  load    = 1'b1;
                  last_in = 1'b1;
                  code_in = replacement_code;
                  repl_in = 1'b1;
               end
               default: begin
                  load = 1'b0;
               end
            endcase
         end
      end
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         code_ff <= code_in;
         repl_ff <= repl_in;
         last_ff <= last_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {3'b000, code_ff};
   assign rsp_tuser  = repl_ff;
   assign rsp_tlast  = last_ff;

endmodule

### hw/rtl/utf8_stream_decoder_core.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder_core
// Byte-serial UTF-8 decoder: one byte in, zero to four code points out.
// ----------------------------------------------------------------------------
// A result passes through the command queue and then the output register.
// Throughput: one byte per cycle while the command queue is not full; the back
// part emits a byte's results one after another, the command queue
// (QUEUE_DEPTH entries) absorbing the difference until it fills.
// Reset is synchronous: sequence state and queue clear, registers return to
// their defaults, and the block accepts bytes on the next cycle.
module utf8_stream_decoder_core
   import u8d_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [BYTE_W-1:0]    req_tdata,   // [7:0] byte_in
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [23:0]          rsp_tdata,   // [20:0] code_point, [23:21] zero
   output logic [0:0]           rsp_tuser,   // [0] was_replaced
   output logic                 rsp_tlast,   // last_of_run
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CODE_W-1:0]    csr_wdata
);

   logic [CODE_W-1:0] replacement_ff;
   logic [CODE_W-1:0] limit_ff;
   logic              queue_full;
   logic              push_valid;
   u8d_cmd_type       push_cmd;
   logic              pop;
   logic              head_valid;
   u8d_cmd_type       head_cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         replacement_ff <= REPLACEMENT_RESET;
         limit_ff       <= CODE_LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_REPLACEMENT_CODE: replacement_ff <= csr_wdata;
            CSR_CODE_LIMIT:       limit_ff       <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   u8d_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_cmd   (push_cmd)
   );

   u8d_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   u8d_back u_back (
      .clock            (clock),
      .reset            (reset),
      .replacement_code (replacement_ff),
      .code_limit       (limit_ff),
      .head_valid       (head_valid),
      .head_cmd         (head_cmd),
      .pop              (pop),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tuser        (rsp_tuser),
      .rsp_tlast        (rsp_tlast)
   );

endmodule

### verif/utf8_stream_decoder_core_test.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder_core_test
// Self-checking bench for the byte-serial UTF-8 decoder. Bytes are pushed
// through the request stream and every code point on the response stream
// is checked field by field against a decoder model kept in the bench.
// Both streams idle at random; the two registers are set several ways.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_core_test
   import u8d_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 10;

   typedef struct packed {
      logic [CODE_W-1:0] code_point;
      logic              was_replaced;
      logic              last_of_run;
   } code_result_type;

   // Decoder model plus the queue of code points it still expects to see.
   class code_point_tracker_type;
      logic [CODE_W-1:0] repl_code;
      logic [CODE_W-1:0] limit_code;
      logic [CODE_W-1:0] acc_value;
      int unsigned       remaining;
      int unsigned       held;
      code_result_type   expected_points[$];
      int                failures;
      int                results_checked;
      int                replaced_count;

      function new();
         repl_code       = REPLACEMENT_RESET;
         limit_code      = CODE_LIMIT_RESET;
         acc_value       = '0;
         remaining       = 0;
         held            = 0;
         failures        = 0;
         results_checked = 0;
         replaced_count  = 0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CODE_W-1:0] val);
         case (idx)
            CSR_REPLACEMENT_CODE: repl_code = val;
            CSR_CODE_LIMIT:       limit_code = val;
            default: ;
         endcase
      endfunction

      function void push_replacement(logic last);
         expected_points.push_back('{repl_code, 1'b1, last});
      endfunction

      function void push_value(logic [CODE_W-1:0] val);
         if (val > limit_code) begin
            push_replacement(1'b1);
         end else begin
            expected_points.push_back('{val, 1'b0, 1'b1});
         end
      endfunction

      function void note_byte(logic [7:0] b);
         if (remaining != 0 && b[7:6] == 2'b10) begin
            acc_value = {acc_value[CODE_W-7:0], b[5:0]};
            remaining--;
            held++;
            if (remaining == 0) begin
               held = 0;
               push_value(acc_value);
               acc_value = '0;
            end
            return;
         end
         // A sequence cut short costs one replacement per byte already held.
         if (remaining != 0) begin
            repeat (held) push_replacement(1'b0);
            remaining = 0;
            held      = 0;
            acc_value = '0;
         end
         if (b[7:6] == 2'b10 || b == LEAD_C0 || b == LEAD_C1 || b >= LEAD_F5) begin
            push_replacement(1'b1);
         end else if (!b[7]) begin
            push_value({13'd0, b});
         end else begin
            if (b[7:5] == 3'b110) begin
               acc_value = {16'd0, b[4:0]};
               remaining = 1;
            end else if (b[7:4] == 4'b1110) begin
               acc_value = {17'd0, b[3:0]};
               remaining = 2;
            end else begin
               acc_value = {18'd0, b[2:0]};
               remaining = 3;
            end
            held = 1;
         end
      endfunction

      function void check_point(logic [23:0] data, logic [0:0] user, logic last);
         code_result_type want;
         results_checked++;
         if (user[0]) replaced_count++;
         if (expected_points.size() == 0) begin
            $error("unexpected code point %h (was_replaced %b, last_of_run %b)",
                   data[CODE_W-1:0], user[0], last);
            failures++;
            return;
         end
         want = expected_points.pop_front();
         if (data[CODE_W-1:0] !== want.code_point) begin
            $error("code_point: expected %h, got %h", want.code_point, data[CODE_W-1:0]);
            failures++;
         end
         if (user[0] !== want.was_replaced) begin
            $error("was_replaced: expected %b, got %b", want.was_replaced, user[0]);
            failures++;
         end
         if (last !== want.last_of_run) begin
            $error("last_of_run: expected %b, got %b", want.last_of_run, last);
            failures++;
         end
      endfunction

      function int pending();
         return expected_points.size();
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [BYTE_W-1:0]    req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [23:0]          rsp_tdata;
   logic [0:0]           rsp_tuser;
   logic                 rsp_tlast;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CODE_W-1:0]    csr_wdata = '0;

   code_point_tracker_type tracker;
   bit                req_calm = 1'b0;
   bit                rsp_calm = 1'b0;
   int                bytes_sent = 0;
   int                idle_cycles = 0;

   logic [7:0] directed_bytes [24] = '{
      8'h00, 8'h7F,                 // ASCII extremes
      8'hC2, 8'h80,                 // smallest two-byte value
      8'hF4, 8'h8F, 8'hBF, 8'hBF,   // largest value the default limit allows
      8'hF4, 8'h90, 8'h80, 8'h80,   // just above the limit
      8'h80, 8'hC0, 8'hC1, 8'hF5, 8'hFF,  // lone continuation and forbidden leads
      8'hF0, 8'h90, 8'h80, 8'h41,   // four-byte sequence cut off after three bytes
      8'hED, 8'hA0, 8'h80           // surrogate passes through undecorated
   };

   always #10 clock = ~clock;

   utf8_stream_decoder_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   function automatic int draw_gap(bit calm);
      if (calm || $urandom_range(0, 3) == 0) return 0;
      return $urandom_range(0, 11);
   endfunction

   task automatic send_byte(logic [7:0] b);
      int gap;
      gap = draw_gap(req_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      tracker.note_byte(b);
      bytes_sent++;
   endtask

   // Mostly well-formed sequences with random content; the rest are
   // truncated sequences and arbitrary bytes.
   task automatic send_random(int count);
      int         sent;
      int         kind;
      int         len;
      int         cut;
      logic [7:0] lead_byte;
      sent = 0;
      while (sent < count) begin
         kind = $urandom_range(0, 9);
         if (kind >= 8) begin
            send_byte(8'($urandom_range(0, 255)));
            sent++;
         end else begin
            len = $urandom_range(1, 4);
            case (len)
               1: lead_byte = 8'($urandom_range(8'h00, 8'h7F));
               2: lead_byte = 8'($urandom_range(8'hC2, 8'hDF));
               3: lead_byte = 8'($urandom_range(8'hE0, 8'hEF));
               default: lead_byte = 8'($urandom_range(8'hF0, 8'hF4));
            endcase
            cut = len;
            if (kind == 7 && len > 1) cut = $urandom_range(1, len - 1);
            send_byte(lead_byte);
            sent++;
            for (int k = 1; k < cut; k++) begin
               send_byte(8'($urandom_range(8'h80, 8'hBF)));
               sent++;
            end
         end
      end
   endtask

   // Holds the sender off until every expected code point is back, then
   // lets a byte still in the pipeline that gives no result work through.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CODE_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      tracker.write_register(idx, val);
   endtask

   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = draw_gap(rsp_calm);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         tracker.check_point(rsp_tdata, rsp_tuser, rsp_tlast);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
         $display("utf8_stream_decoder_core regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      tracker = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
      settle();

      // Everything above zero is over the limit and replaced by zero.
      write_csr(CSR_REPLACEMENT_CODE, '0);
      write_csr(CSR_CODE_LIMIT, '0);
      send_random(60);
      settle();

      // Nothing is over the limit; both streams run without idling.
      write_csr(CSR_REPLACEMENT_CODE, 21'h10FFFF);
      write_csr(CSR_CODE_LIMIT, 21'h1FFFFF);
      req_calm = 1'b1;
      rsp_calm = 1'b1;
      send_random(80);
      settle();
      req_calm = 1'b0;
      rsp_calm = 1'b0;

      write_csr(CSR_REPLACEMENT_CODE, CODE_W'($urandom_range(0, 21'h10FFFF)));
      write_csr(CSR_CODE_LIMIT, CODE_W'($urandom_range(0, 21'h1FFFFF)));
      send_random(80);
      settle();

      write_csr(CSR_REPLACEMENT_CODE, REPLACEMENT_RESET);
      write_csr(CSR_CODE_LIMIT, CODE_LIMIT_RESET);
      send_random(80);
      settle();

      $display("Decoded %0d bytes under five register settings, random and idle-free.",
               bytes_sent);
      $display("Checked %0d code points, %0d of them replacements; %0d mismatches.",
               tracker.results_checked, tracker.replaced_count, tracker.failures);
      if (tracker.failures == 0) begin
         $display("utf8_stream_decoder_core regression: pass");
      end else begin
         $display("utf8_stream_decoder_core regression: fail");
      end
      $finish;
   end

endmodule
